// File: src/m3inv_pkg.sv
`default_nettype none
package m3inv_pkg;

    localparam int NSTG      = 40;
    localparam int LANE_STG  = 34;
    localparam int LANE_BASE = 5;
    localparam int NELEM     = 9;

    typedef logic signed [31:0] t_q16;
    typedef logic signed [64:0] t_cof;
    typedef logic signed [98:0] t_det;

    typedef struct packed {
        logic        ovf;
        logic [31:0] val;
    } t_lane_res;

    typedef struct packed {
        logic        sing;
        logic        ovf;
        logic [31:0] val;
    } t_det_res;

    // Each cofactor is a*b - c*d over flat element indexes (column * 3 + row).
    localparam int COF_A [NELEM] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int COF_B [NELEM] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int COF_C [NELEM] = '{7, 1, 2, 3, 2, 0, 6, 0, 1};
    localparam int COF_D [NELEM] = '{5, 8, 4, 8, 6, 5, 4, 7, 3};

endpackage
`default_nettype wire

// File: src/m3inv_cof.sv
`default_nettype none
module m3inv_cof (
    input  wire logic           i_clk,
    input  wire logic [1:0]     i_en,
    input  wire m3inv_pkg::t_q16 i_a [m3inv_pkg::NELEM],
    output m3inv_pkg::t_cof     o_cof [m3inv_pkg::NELEM],
    output m3inv_pkg::t_q16     o_m0 [3]
);
    import m3inv_pkg::*;

    logic signed [63:0] r_pa [NELEM];
    logic signed [63:0] r_pb [NELEM];
    t_q16               r_m0a [3];
    t_cof               r_cof [NELEM];
    t_q16               r_m0b [3];

    genvar g;
    generate
        for (g = 0; g < NELEM; g++) begin : g_cof
            always_ff @(posedge i_clk) begin
                if (i_en[0]) begin
                    r_pa[g] <= i_a[COF_A[g]] * i_a[COF_B[g]];
                    r_pb[g] <= i_a[COF_C[g]] * i_a[COF_D[g]];
                end
                if (i_en[1]) begin
                    r_cof[g] <= 65'(r_pa[g]) - 65'(r_pb[g]);
                end
            end
            assign o_cof[g] = r_cof[g];
        end
        for (g = 0; g < 3; g++) begin : g_row
            always_ff @(posedge i_clk) begin
                if (i_en[0]) begin
                    r_m0a[g] <= i_a[g];
                end
                if (i_en[1]) begin
                    r_m0b[g] <= r_m0a[g];
                end
            end
            assign o_m0[g] = r_m0b[g];
        end
    endgenerate

endmodule
`default_nettype wire

// File: src/m3inv_det.sv
`default_nettype none
module m3inv_det (
    input  wire logic            i_clk,
    input  wire logic [2:0]      i_en,
    input  wire m3inv_pkg::t_cof i_cof [m3inv_pkg::NELEM],
    input  wire m3inv_pkg::t_q16 i_m0 [3],
    output m3inv_pkg::t_cof      o_cof [m3inv_pkg::NELEM],
    output m3inv_pkg::t_det      o_det
);
    import m3inv_pkg::*;

    logic signed [64:0] r_plo [3];
    logic signed [64:0] r_phi [3];
    logic signed [96:0] r_term [3];
    t_cof               r_c2 [NELEM];
    t_cof               r_c3 [NELEM];
    t_cof               r_c4 [NELEM];
    t_det               r_det;

    // The first-column element at row j pairs with the cofactor at column j, row 0.
    genvar g;
    generate
        for (g = 0; g < 3; g++) begin : g_term
            logic [31:0]        w_lo;
            logic signed [32:0] w_hi;
            assign w_lo = i_cof[g * 3][31:0];
            assign w_hi = i_cof[g * 3][64:32];
            always_ff @(posedge i_clk) begin
                if (i_en[0]) begin
                    r_plo[g] <= i_m0[g] * $signed({1'b0, w_lo});
                    r_phi[g] <= i_m0[g] * w_hi;
                end
                if (i_en[1]) begin
                    r_term[g] <= $signed({r_phi[g][64:0], 32'b0}) + 97'(r_plo[g]);
                end
            end
        end
        for (g = 0; g < NELEM; g++) begin : g_dly
            always_ff @(posedge i_clk) begin
                if (i_en[0]) begin
                    r_c2[g] <= i_cof[g];
                end
                if (i_en[1]) begin
                    r_c3[g] <= r_c2[g];
                end
                if (i_en[2]) begin
                    r_c4[g] <= r_c3[g];
                end
            end
            assign o_cof[g] = r_c4[g];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_det <= 99'(r_term[0]) + 99'(r_term[1]) + 99'(r_term[2]);
        end
    end

    assign o_det = r_det;

endmodule
`default_nettype wire

// File: src/m3inv_lane.sv
`default_nettype none
module m3inv_lane (
    input  wire logic                            i_clk,
    input  wire logic [m3inv_pkg::LANE_STG-1:0] i_en,
    input  wire m3inv_pkg::t_cof                 i_cof,
    input  wire m3inv_pkg::t_det                 i_det,
    output m3inv_pkg::t_lane_res                 o_res
);
    import m3inv_pkg::*;

    localparam int LAST = LANE_STG - 1;

    logic [98:0] r_rem [LANE_STG];
    logic [32:0] r_q   [LANE_STG];
    logic [98:0] r_ad  [LANE_STG];
    logic        r_neg [LANE_STG];
    logic        r_ovf [LANE_STG];
    logic        r_b0;

    logic [64:0] w_an;
    logic [98:0] w_ad;
    logic        w_up;
    logic [33:0] w_q1;
    logic [33:0] w_lim;

    assign w_an = i_cof[64] ? 65'(-i_cof) : 65'(i_cof);
    assign w_ad = i_det[98] ? 99'(-i_det) : 99'(i_det);

    // A quotient of 2^33 or more always saturates, so only 33 quotient bits are formed.
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_rem[0] <= 99'(w_an[64:1]);
            r_q[0]   <= '0;
            r_ad[0]  <= w_ad;
            r_neg[0] <= i_cof[64] ^ i_det[98];
            r_ovf[0] <= {35'b0, w_an} >= {w_ad, 1'b0};
            r_b0     <= w_an[0];
        end
    end

    genvar s;
    generate
        for (s = 1; s < LANE_STG; s++) begin : g_step
            logic [99:0] w_t;
            logic        w_ge;
            logic [99:0] w_d;
            assign w_t  = {r_rem[s-1], (s == 1) ? r_b0 : 1'b0};
            assign w_ge = w_t >= {1'b0, r_ad[s-1]};
            assign w_d  = w_ge ? (w_t - {1'b0, r_ad[s-1]}) : w_t;
            always_ff @(posedge i_clk) begin
                if (i_en[s]) begin
                    r_rem[s] <= w_d[98:0];
                    r_q[s]   <= {r_q[s-1][31:0], w_ge};
                    r_ad[s]  <= r_ad[s-1];
                    r_neg[s] <= r_neg[s-1];
                    r_ovf[s] <= r_ovf[s-1];
                end
            end
        end
    endgenerate

    assign w_up  = {r_rem[LAST], 1'b0} >= {1'b0, r_ad[LAST]};
    assign w_q1  = {1'b0, r_q[LAST]} + 34'(w_up);
    assign w_lim = r_neg[LAST] ? 34'h080000000 : 34'h07FFFFFFF;

    always_comb begin
        if (r_ovf[LAST] || (w_q1 > w_lim)) begin
            o_res.ovf = 1'b1;
            o_res.val = r_neg[LAST] ? 32'h80000000 : 32'h7FFFFFFF;
        end else begin
            o_res.ovf = 1'b0;
            o_res.val = r_neg[LAST] ? (32'd0 - w_q1[31:0]) : w_q1[31:0];
        end
    end

endmodule
`default_nettype wire

// File: src/matrix3_inverse_core.sv
// Throughput: one item per cycle; each stage holds only while the stages after it are full.
// The 33-step pipelined restoring division in each of the nine lanes sets the depth.
// Reset (synchronous, active low) empties every pipeline stage; data registers are not cleared.
`default_nettype none
module matrix3_inverse_core (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // a_c0r0, a_c0r1, a_c0r2, a_c1r0, a_c1r1, a_c1r2, a_c2r0, a_c2r1, a_c2r2
    input  wire logic [287:0] i_s_tdata,
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // inv_c0r0, inv_c0r1, inv_c0r2, inv_c1r0, inv_c1r1, inv_c1r2, inv_c2r0, inv_c2r1,
    // inv_c2r2, det_value
    output logic [319:0]      o_m_tdata,
    // singular, overflow
    output logic [1:0]        o_m_tuser
);
    import m3inv_pkg::*;

    localparam int DLY = LANE_STG;

    logic [NSTG-1:0] r_vld;
    logic [NSTG:0]   w_en;

    t_q16      w_a    [NELEM];
    t_cof      w_cof1 [NELEM];
    t_q16      w_m0   [3];
    t_cof      w_cof4 [NELEM];
    t_det      w_det;
    t_lane_res w_lane [NELEM];

    t_det_res  r_dres [DLY];
    t_det_res  w_dres;
    logic [98:0] w_dabs;
    logic [67:0] w_dq;
    logic [67:0] w_dlim;

    logic [31:0] r_inv [NELEM];
    logic [31:0] r_dval;
    logic        r_sing;
    logic        r_ovf;
    logic        w_lovf;

    assign w_en[NSTG] = i_m_tready;

    genvar k;
    generate
        for (k = 0; k < NSTG; k++) begin : g_en
            assign w_en[k] = !r_vld[k] || w_en[k+1];
        end
        for (k = 0; k < NELEM; k++) begin : g_in
            assign w_a[k] = i_s_tdata[k*32 +: 32];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int i = 0; i < NSTG; i++) begin
                if (w_en[i]) begin
                    r_vld[i] <= (i == 0) ? i_s_tvalid : r_vld[(i == 0) ? 0 : i - 1];
                end
            end
        end
    end

    assign o_s_tready = w_en[0];

    m3inv_cof u_cof (
        .i_clk (i_clk),
        .i_en  (w_en[1:0]),
        .i_a   (w_a),
        .o_cof (w_cof1),
        .o_m0  (w_m0)
    );

    m3inv_det u_det (
        .i_clk (i_clk),
        .i_en  (w_en[4:2]),
        .i_cof (w_cof1),
        .i_m0  (w_m0),
        .o_cof (w_cof4),
        .o_det (w_det)
    );

    generate
        for (k = 0; k < NELEM; k++) begin : g_lane
            m3inv_lane u_lane (
                .i_clk (i_clk),
                .i_en  (w_en[LANE_BASE + LANE_STG - 1:LANE_BASE]),
                .i_cof (w_cof4[k]),
                .i_det (w_det),
                .o_res (w_lane[k])
            );
        end
    endgenerate

    assign w_dabs = w_det[98] ? 99'(-w_det) : 99'(w_det);
    assign w_dq   = {1'b0, w_dabs[98:32]} + 68'(w_dabs[31]);
    assign w_dlim = w_det[98] ? 68'h080000000 : 68'h07FFFFFFF;

    always_comb begin
        w_dres.sing = (w_det == '0);
        if (w_dq > w_dlim) begin
            w_dres.ovf = 1'b1;
            w_dres.val = w_det[98] ? 32'h80000000 : 32'h7FFFFFFF;
        end else begin
            w_dres.ovf = 1'b0;
            w_dres.val = w_det[98] ? (32'd0 - w_dq[31:0]) : w_dq[31:0];
        end
    end

    generate
        for (k = 0; k < DLY; k++) begin : g_dly
            always_ff @(posedge i_clk) begin
                if (w_en[LANE_BASE + k]) begin
                    r_dres[k] <= (k == 0) ? w_dres : r_dres[(k == 0) ? 0 : k - 1];
                end
            end
        end
    endgenerate

    always_comb begin
        w_lovf = r_dres[DLY-1].ovf;
        for (int i = 0; i < NELEM; i++) begin
            w_lovf = w_lovf | w_lane[i].ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[NSTG-1]) begin
            for (int i = 0; i < NELEM; i++) begin
                r_inv[i] <= r_dres[DLY-1].sing ? 32'd0 : w_lane[i].val;
            end
            r_dval <= r_dres[DLY-1].sing ? 32'd0 : r_dres[DLY-1].val;
            r_sing <= r_dres[DLY-1].sing;
            r_ovf  <= !r_dres[DLY-1].sing && w_lovf;
        end
    end

    generate
        for (k = 0; k < NELEM; k++) begin : g_out
            assign o_m_tdata[k*32 +: 32] = r_inv[k];
        end
    endgenerate

    assign o_m_tdata[319:288] = r_dval;
    assign o_m_tuser          = {r_ovf, r_sing};
    assign o_m_tvalid         = r_vld[NSTG-1];

endmodule
`default_nettype wire

// File: bench/tb_matrix3_inverse_core.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_matrix3_inverse_core;

    import m3inv_pkg::*;

    localparam int LATENCY = 40;

    typedef struct packed {
        logic [31:0] det;
        logic [8:0][31:0] inv;
        logic sing;
        logic ovf;
    } t_inverse;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [287:0] i_s_tdata = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [319:0] o_m_tdata;
    logic [1:0]   o_m_tuser;

    t_inverse     inverse_fifo[$];
    int           mismatch_count = 0;
    int           results_seen = 0;
    bit           hold_off = 1'b0;

    matrix3_inverse_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Round num/den to nearest, ties away from zero, saturate to 32 bits.
    function automatic logic [31:0] round_sat(input logic signed [160:0] num,
                                              input logic signed [160:0] den,
                                              inout logic ovf);
        logic [160:0] n, d, q, r;
        logic         neg;
        neg = num[160] ^ den[160];
        n = num[160] ? -num : num;
        d = den[160] ? -den : den;
        q = n / d;
        r = n % d;
        if (r >= d - r) begin
            q = q + 1;
        end
        if (!neg && q > 161'h7FFFFFFF) begin
            ovf = 1'b1;
            return 32'h7FFFFFFF;
        end
        if (neg && q > 161'h80000000) begin
            ovf = 1'b1;
            return 32'h80000000;
        end
        return neg ? 32'(-q) : q[31:0];
    endfunction

    function automatic t_inverse invert_matrix(input logic [287:0] data);
        logic signed [160:0] e [9];
        logic signed [160:0] adj [9];
        logic signed [160:0] det;
        t_inverse            res;
        logic                ovf;
        for (int i = 0; i < 9; i++) begin
            e[i] = 161'(signed'(data[i*32 +: 32]));
        end
        adj[0] = e[4]*e[8] - e[7]*e[5];
        adj[1] = e[2]*e[7] - e[1]*e[8];
        adj[2] = e[1]*e[5] - e[2]*e[4];
        adj[3] = e[5]*e[6] - e[3]*e[8];
        adj[4] = e[0]*e[8] - e[2]*e[6];
        adj[5] = e[2]*e[3] - e[0]*e[5];
        adj[6] = e[3]*e[7] - e[6]*e[4];
        adj[7] = e[1]*e[6] - e[0]*e[7];
        adj[8] = e[0]*e[4] - e[1]*e[3];
        det = e[0]*adj[0] - e[1]*(e[3]*e[8] - e[6]*e[5]) + e[2]*(e[3]*e[7] - e[6]*e[4]);
        res = '0;
        ovf = 1'b0;
        if (det == 0) begin
            res.sing = 1'b1;
            return res;
        end
        for (int i = 0; i < 9; i++) begin
            res.inv[i] = round_sat(adj[i] <<< 32, det, ovf);
        end
        res.det = round_sat(det, 161'sd1 <<< 32, ovf);
        res.ovf = ovf;
        return res;
    endfunction

    function automatic logic [31:0] rand_element();
        case ($urandom_range(0, 9))
            0: return 32'h80000000;
            1: return 32'h7FFFFFFF;
            2: return 32'(int'($urandom_range(0, 8)) - 4) <<< 16;
            3: return 32'($urandom_range(0, 4)) - 2;
            4, 5: return 32'(int'($urandom_range(0, 32'h3FFFF)) - 32'h1FFFF);
            6, 7: return 32'(int'($urandom_range(0, 32'h7FFFFF)) - 32'h3FFFFF);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [287:0] rand_matrix();
        logic [287:0] m;
        for (int i = 0; i < 9; i++) begin
            m[i*32 +: 32] = rand_element();
        end
        // Sometimes copy row 0 into row 2 so the matrix is exactly singular.
        if ($urandom_range(0, 9) == 0) begin
            m[64 +: 32] = m[0 +: 32];
            m[160 +: 32] = m[96 +: 32];
            m[256 +: 32] = m[192 +: 32];
        end
        return m;
    endfunction

    function automatic logic [287:0] diag(input logic [31:0] a, input logic [31:0] b,
                                          input logic [31:0] c);
        logic [287:0] m;
        m = '0;
        m[0 +: 32] = a;
        m[128 +: 32] = b;
        m[256 +: 32] = c;
        return m;
    endfunction

    task automatic send_matrix(input logic [287:0] m);
        i_s_tdata <= m;
        i_s_tvalid <= 1'b1;
        inverse_fifo.push_back(invert_matrix(m));
        @(posedge i_clk);
        while (!o_s_tready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic send_gap();
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            i_m_tready <= !hold_off && ($urandom_range(0, 4) != 0 || results_seen % 200 > 150);
        end
    end

    // The receiver holds off for a long stretch while the sender keeps offering items.
    initial begin
        wait (results_seen >= 300);
        hold_off = 1'b1;
        repeat (300) @(posedge i_clk);
        hold_off = 1'b0;
    end

    always @(posedge i_clk) begin
        t_inverse got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_seen <= results_seen + 1;
            got.inv = o_m_tdata[287:0];
            got.det = o_m_tdata[319:288];
            got.sing = o_m_tuser[0];
            got.ovf = o_m_tuser[1];
            if (inverse_fifo.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected result item %h", got);
                end
            end else begin
                want = inverse_fifo.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch: expected inv %h det %h sing %b ovf %b",
                                 want.inv, want.det, want.sing, want.ovf);
                        $display("          actual   inv %h det %h sing %b ovf %b",
                                 got.inv, got.det, got.sing, got.ovf);
                    end
                end
            end
        end
    end

    initial begin
        #5000000;
        $display("tb_matrix3_inverse_core: FAIL");
        $finish;
    end

    initial begin
        logic [287:0] directed [10];
        logic [31:0]  one;
        one = 32'h10000;
        directed[0] = diag(one, one, one);
        directed[1] = '0;
        directed[2] = diag(32'h20000, 32'hFFFF0000, 32'h8000);
        directed[3] = diag(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        directed[4] = diag(32'h80000000, 32'h80000000, 32'h80000000);
        directed[5] = diag(32'd1, 32'd1, 32'd1);
        directed[6] = diag(32'd2, one, one);
        directed[7] = {9{32'hFFFFFFFF}};
        directed[8] = diag(32'h80000000, 32'h7FFFFFFF, 32'd1);
        directed[9] = 288'h0001_0000_0000_0000_0000_0000_0002_0000_0000_0001_0000_0000_0000_0000_0003_0000_0000_0000;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < 10; i++) begin
            send_matrix(directed[i]);
        end
        i_s_tvalid <= 1'b0;

        // Sender pauses until every result is back.
        while (inverse_fifo.size() != 0) begin
            @(posedge i_clk);
        end

        for (int i = 0; i < 1500; i++) begin
            send_matrix(rand_matrix());
            send_gap();
        end
        i_s_tvalid <= 1'b0;

        while (inverse_fifo.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (LATENCY + 10) @(posedge i_clk);

        if (mismatch_count == 0 && inverse_fifo.size() == 0) begin
            $display("tb_matrix3_inverse_core: PASS");
        end else begin
            $display("tb_matrix3_inverse_core: FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire

// File: filelist.f
src/m3inv_pkg.sv
src/m3inv_cof.sv
src/m3inv_det.sv
src/m3inv_lane.sv
src/matrix3_inverse_core.sv
bench/tb_matrix3_inverse_core.sv
